// ===== sv/terrain_grid_index_generator_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TERRAIN_GRID_INDEX_GENERATOR_DEFINES_SVH
`define TERRAIN_GRID_INDEX_GENERATOR_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define TGIG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Clocked assertion that applies only while a qualifier is high.
`define TGIG_ASSERT_WHEN(lbl, clk, rst_n, qual, prop, msg) \
	`TGIG_ASSERT(lbl, clk, rst_n, (qual) |-> (prop), msg)

`endif

// ===== sv/tgig_pkg.sv =====
package tgig_pkg;

	// Sizes
	localparam int MAX_SHIFT   = 7;
	localparam int SHIFT_BITS  = 3;
	localparam int COUNT_BITS  = MAX_SHIFT;
	localparam int INDEX_BITS  = 16;
	localparam int FIELD_BITS  = 16;
	localparam int REGION_BITS = 3;

	localparam logic [SHIFT_BITS-1:0] GRID_SHIFT_RESET = SHIFT_BITS'(4);

	// Region codes, also the sequencing phase
	localparam logic [REGION_BITS-1:0] REGION_GRID   = 3'd0;
	localparam logic [REGION_BITS-1:0] REGION_TOP    = 3'd1;
	localparam logic [REGION_BITS-1:0] REGION_RIGHT  = 3'd2;
	localparam logic [REGION_BITS-1:0] REGION_BOTTOM = 3'd3;
	localparam logic [REGION_BITS-1:0] REGION_LEFT   = 3'd4;

	typedef logic [INDEX_BITS-1:0] idx_t;
	typedef logic [FIELD_BITS-1:0] field_t;

	// Position of the next quad to emit
	typedef struct packed {
		logic [REGION_BITS-1:0] phase;
		logic [COUNT_BITS-1:0]  row;
		logic [COUNT_BITS-1:0]  col;
	} pos_t;

	// One quad: two triangles plus tags
	typedef struct packed {
		field_t                 tri0_a;
		field_t                 tri0_b;
		field_t                 tri0_c;
		field_t                 tri1_a;
		field_t                 tri1_b;
		field_t                 tri1_c;
		logic [REGION_BITS-1:0] region;
		logic                   end_of_list;
	} quad_t;

endpackage

// ===== sv/tgig_if.sv =====
// Request channel: one transfer asks for the next quad
interface tgig_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// Result channel: one quad per transfer
interface tgig_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] tri0_a;
	logic [15:0] tri0_b;
	logic [15:0] tri0_c;
	logic [15:0] tri1_a;
	logic [15:0] tri1_b;
	logic [15:0] tri1_c;
	logic [2:0]  region;
	logic        end_of_list;

	modport source (output valid, output tri0_a, output tri0_b, output tri0_c,
		output tri1_a, output tri1_b, output tri1_c, output region,
		output end_of_list, input ready);
	modport sink (input valid, input tri0_a, input tri0_b, input tri0_c,
		input tri1_a, input tri1_b, input tri1_c, input region,
		input end_of_list, output ready);
endinterface

// ===== sv/tgig_quad.sv =====
// Quad index calculation and position advance for one request.
module tgig_quad import tgig_pkg::*; (
	input  logic [SHIFT_BITS-1:0] grid_shift,
	input  logic                  restart,
	input  pos_t                  pos,
	output quad_t                 quad,
	output pos_t                  pos_next
);

	logic [SHIFT_BITS-1:0]  s;
	logic                   stale;
	logic [REGION_BITS-1:0] ph;
	logic                   last;
	idx_t m, n, nn, r, c, b, j, s0, s1, e0, e1, c1, r1;

	// Clamp the shift into the supported range
	always_comb begin
		if (grid_shift == '0) begin
			s = SHIFT_BITS'(1);
		end else if (grid_shift > SHIFT_BITS'(MAX_SHIFT)) begin
			s = SHIFT_BITS'(MAX_SHIFT);
		end else begin
			s = grid_shift;
		end
	end

	// Grid sizes: m quads per edge, n vertices per edge, nn grid vertices
	assign m  = idx_t'(1) << s;
	assign n  = m + idx_t'(1);
	assign nn = (m << s) + (m << 1) + idx_t'(1);

	// Restart, or fall back to the first quad when the position is out of range
	assign stale = restart || (pos.phase > REGION_LEFT)
		|| (idx_t'(pos.row) >= m) || (idx_t'(pos.col) >= m);
	assign ph = stale ? REGION_GRID : pos.phase;
	assign r  = stale ? '0 : idx_t'(pos.row);
	assign c  = stale ? '0 : idx_t'(pos.col);

	// Shared terms: grid base vertex, skirt vertices, mirrored column
	assign b  = (r << s) + r + c;
	assign s0 = nn + (idx_t'(ph - REGION_TOP) << s) + c;
	assign j  = m - c;

	// Form the six indices
	always_comb begin
		e0   = '0;
		e1   = '0;
		s1   = s0 + idx_t'(1);
		last = 1'b0;
		quad = '0;
		unique case (ph)
			REGION_TOP: begin
				e0 = c;
				e1 = c + idx_t'(1);
			end
			REGION_RIGHT: begin
				e0 = (c << s) + c + m;
				e1 = e0 + n;
			end
			REGION_BOTTOM: begin
				e0 = nn - idx_t'(1) - c;
				e1 = e0 - idx_t'(1);
			end
			REGION_LEFT: begin
				e0 = (j << s) + j;
				e1 = e0 - n;
				// close the skirt ring on the first skirt vertex
				if (c == m - idx_t'(1)) begin
					s1   = nn;
					last = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (ph == REGION_GRID) begin
			quad.tri0_a = b[FIELD_BITS-1:0];
			quad.tri0_b = FIELD_BITS'(b + idx_t'(1));
			quad.tri0_c = FIELD_BITS'(b + n + idx_t'(1));
			quad.tri1_a = b[FIELD_BITS-1:0];
			quad.tri1_b = FIELD_BITS'(b + n + idx_t'(1));
			quad.tri1_c = FIELD_BITS'(b + n);
		end else begin
			quad.tri0_a = e0[FIELD_BITS-1:0];
			quad.tri0_b = s0[FIELD_BITS-1:0];
			quad.tri0_c = e1[FIELD_BITS-1:0];
			quad.tri1_a = e1[FIELD_BITS-1:0];
			quad.tri1_b = s0[FIELD_BITS-1:0];
			quad.tri1_c = s1[FIELD_BITS-1:0];
		end
		quad.region      = ph;
		quad.end_of_list = last;
	end

	// Advance to the next quad
	assign c1 = c + idx_t'(1);
	assign r1 = r + idx_t'(1);

	always_comb begin
		pos_next.phase = ph;
		pos_next.row   = r[COUNT_BITS-1:0];
		pos_next.col   = c1[COUNT_BITS-1:0];
		if (c1 == m) begin
			pos_next.col = '0;
			if (ph == REGION_GRID) begin
				if (r1 == m) begin
					pos_next.row   = '0;
					pos_next.phase = REGION_TOP;
				end else begin
					pos_next.row = r1[COUNT_BITS-1:0];
				end
			end else if (ph == REGION_LEFT) begin
				pos_next.phase = REGION_GRID;
			end else begin
				pos_next.phase = ph + REGION_TOP;
			end
		end
	end

endmodule

// ===== sv/terrain_grid_index_generator.sv =====
// Channel   Dir  Payload
// item      in   restart
// result    out  tri0_a..tri1_c, region, end_of_list
// cfg_wr_*  in   grid_shift (write only)
//
// One request per cycle while the result is not stalled; each request's quad is on
// the result in the cycle after its transfer, held in the output register.
// The request side stays ready while the output register is empty or is being
// drained, so a stalled result stops new requests only for the stall.
// Reset sets grid_shift to 4 and the position to the first grid quad.
module terrain_grid_index_generator import tgig_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [SHIFT_BITS-1:0] cfg_wr_data,
	tgig_in_if.sink               item,
	tgig_out_if.source            result
);

	logic [SHIFT_BITS-1:0] grid_shift_q;
	pos_t                  pos_q;
	pos_t                  pos_next;
	quad_t                 quad;
	quad_t                 quad_q;
	logic                  out_valid_q;
	logic                  accept;

	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	// Hold the tessellation shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_shift_q <= GRID_SHIFT_RESET;
		end else if (cfg_wr_en) begin
			grid_shift_q <= cfg_wr_data;
		end
	end

	tgig_quad u_quad (
		.grid_shift (grid_shift_q),
		.restart    (item.restart),
		.pos        (pos_q),
		.quad       (quad),
		.pos_next   (pos_next)
	);

	// Advance the position on each request transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= pos_next;
		end
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			quad_q <= quad;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.tri0_a      = quad_q.tri0_a;
	assign result.tri0_b      = quad_q.tri0_b;
	assign result.tri0_c      = quad_q.tri0_c;
	assign result.tri1_a      = quad_q.tri1_a;
	assign result.tri1_b      = quad_q.tri1_b;
	assign result.tri1_c      = quad_q.tri1_c;
	assign result.region      = quad_q.region;
	assign result.end_of_list = quad_q.end_of_list;

endmodule

// ===== sv/tgig_checker.sv =====
`include "terrain_grid_index_generator_defines.svh"

// Port-level checks on the index generator.
module tgig_checker import tgig_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   in_restart,
	input logic                   out_valid,
	input logic [FIELD_BITS-1:0]  tri0_a,
	input logic [FIELD_BITS-1:0]  tri0_b,
	input logic [FIELD_BITS-1:0]  tri0_c,
	input logic [FIELD_BITS-1:0]  tri1_a,
	input logic [FIELD_BITS-1:0]  tri1_b,
	input logic [REGION_BITS-1:0] region,
	input logic                   end_of_list
);

	// A restart transfer yields the first grid quad next cycle
	`TGIG_ASSERT(a_restart_first_quad, clk, arst_n, (in_valid && in_ready && in_restart) |=> (out_valid && tri0_a == '0 && region == REGION_GRID), "restart did not give the first grid quad")

	// Only the left skirt carries the end-of-list mark
	`TGIG_ASSERT_WHEN(a_end_on_left, clk, arst_n, out_valid && end_of_list, region == REGION_LEFT, "end_of_list outside the left skirt")

	// Grid quads share their corner vertex and step one column
	`TGIG_ASSERT_WHEN(a_grid_shape, clk, arst_n, out_valid && region == REGION_GRID, tri1_a == tri0_a && tri0_b == tri0_a + 16'd1 && tri1_b == tri0_c, "grid quad shape broken")

	// Skirt quads share the edge and skirt vertices between the triangles
	`TGIG_ASSERT_WHEN(a_skirt_shape, clk, arst_n, out_valid && region != REGION_GRID, tri1_a == tri0_c && tri1_b == tri0_b && region <= REGION_LEFT, "skirt quad shape broken")

endmodule

bind terrain_grid_index_generator tgig_checker u_tgig_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.in_restart  (item.restart),
	.out_valid   (result.valid),
	.tri0_a      (result.tri0_a),
	.tri0_b      (result.tri0_b),
	.tri0_c      (result.tri0_c),
	.tri1_a      (result.tri1_a),
	.tri1_b      (result.tri1_b),
	.region      (result.region),
	.end_of_list (result.end_of_list)
);
